// ===== design/mandelbrot_escape_iteration_defines.svh =====
// Assertion macros shared by the checker of the escape-time block.
`ifndef MANDELBROT_ESCAPE_ITERATION_DEFINES_SVH
`define MANDELBROT_ESCAPE_ITERATION_DEFINES_SVH

// Check a consequence in the same cycle as its cause.
`define MBE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its cause.
`define MBE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/mbe_pkg.sv =====
// Types, constants and fixed-point helpers of the escape-time block.
package mbe_pkg;

  localparam int FX_W      = 48;
  localparam int FX_FRAC   = 40;
  localparam int ITER_W    = 11;
  localparam int ROW_W     = 11;
  localparam int SIZE_W    = 12;
  localparam int CTR_W     = 15;
  localparam int ZOOM_W    = 32;
  localparam int DEN_W     = SIZE_W + ZOOM_W;
  localparam int NUM_W     = 19;
  localparam int MAG_W     = NUM_W - 1;
  localparam int MAP_SHIFT = 65;
  localparam int MAX_SIZE  = 2048;
  localparam int DEF_MAX_ITER = 1024;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 32;

  typedef logic signed [FX_W-1:0] fx_t;

  localparam fx_t FX_MAXV = {1'b0, {(FX_W-1){1'b1}}};
  localparam fx_t FX_MINV = {1'b1, {(FX_W-1){1'b0}}};
  localparam logic [FX_W:0] FX_TWO = (FX_W+1)'(2) << FX_FRAC;
  localparam logic [FX_W+1:0] FX_OVF_MAG = (FX_W+2)'(1) << FX_W;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_SIZE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ZOOM_SCALE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER   = 3'd4;

  localparam logic [SIZE_W-1:0] RST_IMAGE_SIZE = 12'd800;
  localparam logic [ZOOM_W-1:0] RST_ZOOM_SCALE = 32'd8388608;
  localparam logic [ITER_W-1:0] RST_MAX_ITER   = 11'd100;

  typedef struct packed {
    fx_t re;
    fx_t im;
  } coord_t;

  // Registered partial products of one Q8.40 multiply
  typedef struct packed {
    logic        neg;
    logic [47:0] hh;
    logic [47:0] hl;
    logic [47:0] lh;
    logic [47:0] ll;
  } fxm_part_t;

  typedef enum logic [1:0] {F_IDLE, F_PREP, F_DIV} frt_state_t;
  typedef enum logic [2:0] {B_IDLE, B_MUL, B_PROD, B_UPD, B_DONE} eng_state_t;

  // Signed value from sign and magnitude, clamped to the Q8.40 range
  function automatic fx_t fx_from_mag(input logic neg, input logic [FX_W+1:0] mag);
    fx_t r;
    if (neg) begin
      if (mag >= (FX_W+2)'(1) << (FX_W-1)) r = FX_MINV;
      else r = -fx_t'(mag[FX_W-1:0]);
    end else begin
      if (mag > {2'b00, FX_MAXV}) r = FX_MAXV;
      else r = fx_t'(mag[FX_W-1:0]);
    end
    return r;
  endfunction

  function automatic logic [FX_W-1:0] fx_mag(input fx_t v);
    logic [FX_W-1:0] m;
    m = v[FX_W-1] ? FX_W'(-v) : FX_W'(v);
    return m;
  endfunction

  // Clamp a 49-bit signed sum to the Q8.40 range
  function automatic fx_t fx_sat(input logic signed [FX_W:0] s);
    fx_t r;
    if (s > $signed({FX_MAXV[FX_W-1], FX_MAXV})) r = FX_MAXV;
    else if (s < $signed({FX_MINV[FX_W-1], FX_MINV})) r = FX_MINV;
    else r = s[FX_W-1:0];
    return r;
  endfunction

  function automatic fx_t fx_add(input fx_t a, input fx_t b);
    logic signed [FX_W:0] s;
    s = {a[FX_W-1], a} + {b[FX_W-1], b};
    return fx_sat(s);
  endfunction

  function automatic fx_t fx_sub(input fx_t a, input fx_t b);
    logic signed [FX_W:0] s;
    s = {a[FX_W-1], a} - {b[FX_W-1], b};
    return fx_sat(s);
  endfunction

  // First half of a multiply: four 24x24 partial products
  function automatic fxm_part_t fxm_start(input fx_t a, input fx_t b);
    fxm_part_t p;
    logic [47:0] ma;
    logic [47:0] mb;
    logic [23:0] a1, a0, b1, b0;
    ma = fx_mag(a);
    mb = fx_mag(b);
    a1 = ma[47:24];
    a0 = ma[23:0];
    b1 = mb[47:24];
    b0 = mb[23:0];
    p.neg = a[FX_W-1] ^ b[FX_W-1];
    p.hh  = {24'd0, a1} * {24'd0, b1};
    p.hl  = {24'd0, a1} * {24'd0, b0};
    p.lh  = {24'd0, a0} * {24'd0, b1};
    p.ll  = {24'd0, a0} * {24'd0, b0};
    return p;
  endfunction

  // Second half: combine, truncate toward zero, saturate
  function automatic fx_t fxm_finish(input fxm_part_t p);
    logic [48:0] mid;
    logic [48:0] low;
    logic [49:0] res;
    mid = {1'b0, p.hl} + {1'b0, p.lh};
    low = {1'b0, p.ll} + {9'd0, mid[15:0], 24'd0};
    res = {2'b00, p.hh[39:0], 8'd0} + {17'd0, mid[48:16]} + {41'd0, low[48:40]};
    if (p.hh[47:40] != 8'd0) res = FX_OVF_MAG;
    return fx_from_mag(p.neg, res);
  endfunction

endpackage

// ===== design/mandelbrot_escape_iteration.sv =====
// Top level of the Mandelbrot escape-time block.
//
// Input channel: a pixel (row, column) is taken when push is high and full
// is low. Result channel: the escape count of the oldest finished pixel sits
// on out_iterations while empty is low and leaves when pop is high.
// Configuration: cfg_ready is always high; a word is written to register
// cfg_index when cfg_valid is high. Write only while the block is idle.
// The front end maps a pixel with two bit-serial dividers (a setup step,
// 83 quotient bits, a hand-off) and takes no new pixel until it has handed
// the last one off. A two-entry queue hands c to the iteration engine: a
// load step, then n + 1 passes for n iterations, each pass computing the
// partial products, combining them and updating z, and a final step that
// posts the count. Results wait in a two-entry output queue; when the
// receiver stalls the engine holds its finished count, the front end
// fills the middle queue and then keeps full high. Reset empties both
// queues, stops both ends and loads the default configuration.
module mandelbrot_escape_iteration #(
  parameter int MAX_ITER = mbe_pkg::DEF_MAX_ITER
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            push,
  output logic                            full,
  input  logic [mbe_pkg::ROW_W-1:0]       in_pixel_row,
  input  logic [mbe_pkg::ROW_W-1:0]       in_pixel_col,
  output logic                            empty,
  input  logic                            pop,
  output logic [mbe_pkg::ITER_W-1:0]      out_iterations,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mbe_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mbe_pkg::CFG_DAT_W-1:0]   cfg_data
);
  import mbe_pkg::*;

  logic [SIZE_W-1:0]        image_size_r;
  logic signed [CTR_W-1:0]  offset_x_r, offset_y_r;
  logic [ZOOM_W-1:0]        zoom_scale_r;
  logic [ITER_W-1:0]        max_iterations_r;

  logic   cq_push, cq_full, cq_pop, cq_empty;
  coord_t cq_wdata, cq_rdata;
  logic   rq_push, rq_full;
  logic [ITER_W-1:0] rq_wdata;

  assign cfg_ready = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_size_r     <= RST_IMAGE_SIZE;
      offset_x_r       <= '0;
      offset_y_r       <= '0;
      zoom_scale_r     <= RST_ZOOM_SCALE;
      max_iterations_r <= RST_MAX_ITER;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_IMAGE_SIZE: image_size_r     <= cfg_data[SIZE_W-1:0];
        CFG_CENTER_X:   offset_x_r       <= cfg_data[CTR_W-1:0];
        CFG_CENTER_Y:   offset_y_r       <= cfg_data[CTR_W-1:0];
        CFG_ZOOM_SCALE: zoom_scale_r     <= cfg_data[ZOOM_W-1:0];
        CFG_MAX_ITER:   max_iterations_r <= cfg_data[ITER_W-1:0];
        default: ;
      endcase
    end
  end

  mbe_front u_front (
    .clk(clk), .rst_n(rst_n),
    .push(push), .full(full),
    .pixel_row(in_pixel_row), .pixel_col(in_pixel_col),
    .image_size(image_size_r), .offset_x(offset_x_r), .offset_y(offset_y_r),
    .zoom_scale(zoom_scale_r),
    .q_push(cq_push), .q_data(cq_wdata), .q_full(cq_full)
  );

  mbe_fifo #(.WIDTH($bits(coord_t)), .DEPTH(2)) u_cq (
    .clk(clk), .rst_n(rst_n),
    .push(cq_push), .wdata(cq_wdata), .full(cq_full),
    .pop(cq_pop), .rdata(cq_rdata), .empty(cq_empty)
  );

  mbe_engine #(.MAX_ITER(MAX_ITER)) u_engine (
    .clk(clk), .rst_n(rst_n),
    .q_pop(cq_pop), .q_data(cq_rdata), .q_empty(cq_empty),
    .max_iterations(max_iterations_r),
    .res_push(rq_push), .res_data(rq_wdata), .res_full(rq_full)
  );

  mbe_fifo #(.WIDTH(ITER_W), .DEPTH(2)) u_rq (
    .clk(clk), .rst_n(rst_n),
    .push(rq_push), .wdata(rq_wdata), .full(rq_full),
    .pop(pop), .rdata(out_iterations), .empty(empty)
  );
endmodule

// ===== design/mbe_fifo.sv =====
// Small first-in first-out queue of words.
module mbe_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]      cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == (AW+1)'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr_r];

  // Advance pointers and the fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
    if (do_pop)  rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    else if (do_pop && !do_push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the incoming word
  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr_r] <= wdata;
  end
endmodule

// ===== design/mbe_div.sv =====
// Bit-serial divider that maps one pixel offset to a Q8.40 coordinate.
module mbe_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [mbe_pkg::NUM_W-1:0]  num,
  input  logic [mbe_pkg::DEN_W-1:0]         den,
  output logic                              done,
  output mbe_pkg::fx_t                      quo
);
  import mbe_pkg::*;

  localparam int STEPS = MAG_W + MAP_SHIFT;
  localparam int CW    = $clog2(STEPS + 1);

  logic                 run_r, run_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [MAG_W-1:0]     sh_r;
  logic [DEN_W-1:0]     rem_r;
  logic [FX_W-1:0]      q_r;
  logic                 ovf_r, neg_r, zero_r;
  logic [DEN_W:0]       rem_s;
  logic [DEN_W:0]       rem_d;
  logic                 ge;
  logic [NUM_W-1:0]     num_abs;

  assign rem_s   = {rem_r, sh_r[MAG_W-1]};
  assign rem_d   = rem_s - {1'b0, den};
  assign ge      = (rem_s >= {1'b0, den});
  assign num_abs = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
  assign done    = !run_r;

  // Saturate when any quotient bit reached the sign position
  always_comb begin
    if (zero_r) quo = '0;
    else if (ovf_r || q_r[FX_W-1]) quo = fx_from_mag(neg_r, FX_OVF_MAG);
    else quo = fx_from_mag(neg_r, {2'b00, q_r});
  end

  always_comb begin
    run_nxt = run_r;
    cnt_nxt = cnt_r;
    if (start) begin
      run_nxt = 1'b1;
      cnt_nxt = CW'(STEPS);
    end else if (run_r) begin
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) run_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      run_r <= run_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Load the operand, then shift one dividend bit in per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      sh_r   <= num_abs[MAG_W-1:0];
      rem_r  <= '0;
      q_r    <= '0;
      ovf_r  <= 1'b0;
      neg_r  <= num[NUM_W-1];
      zero_r <= (num == '0);
    end else if (run_r) begin
      sh_r  <= {sh_r[MAG_W-2:0], 1'b0};
      rem_r <= ge ? rem_d[DEN_W-1:0] : rem_s[DEN_W-1:0];
      q_r   <= {q_r[FX_W-2:0], ge};
      ovf_r <= ovf_r | q_r[FX_W-1];
    end
  end
endmodule

// ===== design/mbe_front.sv =====
// Front end: takes a pixel and maps it to the point c.
module mbe_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               push,
  output logic                               full,
  input  logic [mbe_pkg::ROW_W-1:0]          pixel_row,
  input  logic [mbe_pkg::ROW_W-1:0]          pixel_col,
  input  logic [mbe_pkg::SIZE_W-1:0]         image_size,
  input  logic signed [mbe_pkg::CTR_W-1:0]   offset_x,
  input  logic signed [mbe_pkg::CTR_W-1:0]   offset_y,
  input  logic [mbe_pkg::ZOOM_W-1:0]         zoom_scale,
  output logic                               q_push,
  output mbe_pkg::coord_t                    q_data,
  input  logic                               q_full
);
  import mbe_pkg::*;

  frt_state_t            state_r, state_nxt;
  logic [ROW_W-1:0]      row_r, col_r;
  logic [DEN_W-1:0]      den_r;
  logic [SIZE_W-1:0]     size;
  logic signed [NUM_W-1:0] num_re, num_im;
  logic                  start;
  logic                  done_re, done_im;
  fx_t                   quo_re, quo_im;

  // Clamp the image size
  assign size = (image_size > SIZE_W'(MAX_SIZE)) ? SIZE_W'(MAX_SIZE) : image_size;

  // Doubled offsets: 2*col - size - 2*center
  assign num_re = {{(NUM_W-ROW_W-1){1'b0}}, col_r, 1'b0}
                - {{(NUM_W-SIZE_W){1'b0}}, size}
                - {{(NUM_W-CTR_W-1){offset_x[CTR_W-1]}}, offset_x, 1'b0};
  assign num_im = {{(NUM_W-ROW_W-1){1'b0}}, row_r, 1'b0}
                - {{(NUM_W-SIZE_W){1'b0}}, size}
                - {{(NUM_W-CTR_W-1){offset_y[CTR_W-1]}}, offset_y, 1'b0};

  mbe_div u_div_re (
    .clk(clk), .rst_n(rst_n), .start(start), .num(num_re), .den(den_r),
    .done(done_re), .quo(quo_re)
  );
  mbe_div u_div_im (
    .clk(clk), .rst_n(rst_n), .start(start), .num(num_im), .den(den_r),
    .done(done_im), .quo(quo_im)
  );

  assign q_data.re = quo_re;
  assign q_data.im = quo_im;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE: if (push) state_nxt = F_PREP;
      F_PREP: state_nxt = F_DIV;
      F_DIV:  if (done_re && done_im && !q_full) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  // Outputs of the state machine
  always_comb begin
    full   = 1'b1;
    start  = 1'b0;
    q_push = 1'b0;
    unique case (state_r)
      F_IDLE: full = 1'b0;
      F_PREP: start = 1'b1;
      F_DIV:  q_push = done_re && done_im && !q_full;
      default: full = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= F_IDLE;
    else state_r <= state_nxt;
  end

  // Hold the pixel and the divisor
  always_ff @(posedge clk) begin
    if (push && !full) begin
      row_r <= pixel_row;
      col_r <= pixel_col;
    end
    if (start) den_r <= DEN_W'(size) * DEN_W'(zoom_scale);
  end
endmodule

// ===== design/mbe_engine.sv =====
// Back end: iterates z = z*z + c until escape or the limit.
module mbe_engine #(
  parameter int MAX_ITER = mbe_pkg::DEF_MAX_ITER
) (
  input  logic                        clk,
  input  logic                        rst_n,
  output logic                        q_pop,
  input  mbe_pkg::coord_t             q_data,
  input  logic                        q_empty,
  input  logic [mbe_pkg::ITER_W-1:0]  max_iterations,
  output logic                        res_push,
  output logic [mbe_pkg::ITER_W-1:0]  res_data,
  input  logic                        res_full
);
  import mbe_pkg::*;

  localparam int CNT_W = $clog2(MAX_ITER + 1);

  eng_state_t        state_r, state_nxt;
  fx_t               cr_r, ci_r, zr_r, zi_r;
  fx_t               rr_r, ii_r, ri_r;
  fxm_part_t         p_rr_r, p_ii_r, p_ri_r;
  logic [CNT_W-1:0]  k_r;
  logic [CNT_W-1:0]  lim;
  logic              finish;
  logic [FX_W:0]     norm;
  fx_t               nr, ni;

  // Effective iteration limit
  always_comb begin
    if (max_iterations == '0) lim = CNT_W'(1);
    else if (32'(max_iterations) > MAX_ITER) lim = CNT_W'(MAX_ITER);
    else lim = CNT_W'(max_iterations);
  end

  // Escape test and next z from the products of the current z
  assign norm   = {1'b0, rr_r} + {1'b0, ii_r};
  assign finish = (k_r != '0) && ((norm >= FX_TWO) || (k_r >= lim));
  assign nr     = fx_add(fx_sub(rr_r, ii_r), cr_r);
  assign ni     = fx_add(fx_add(ri_r, ri_r), ci_r);
  assign res_data = ITER_W'(k_r);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: if (!q_empty) state_nxt = B_MUL;
      B_MUL:  state_nxt = B_PROD;
      B_PROD: state_nxt = B_UPD;
      B_UPD:  state_nxt = finish ? B_DONE : B_MUL;
      B_DONE: if (!res_full) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  // Outputs of the state machine
  always_comb begin
    q_pop    = 1'b0;
    res_push = 1'b0;
    unique case (state_r)
      B_IDLE: q_pop = !q_empty;
      B_DONE: res_push = !res_full;
      default: q_pop = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= B_IDLE;
    else state_r <= state_nxt;
  end

  // Datapath: partial products, combine, update
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cr_r <= q_data.re;
      ci_r <= q_data.im;
      zr_r <= '0;
      zi_r <= '0;
      k_r  <= '0;
    end
    if (state_r == B_MUL) begin
      p_rr_r <= fxm_start(zr_r, zr_r);
      p_ii_r <= fxm_start(zi_r, zi_r);
      p_ri_r <= fxm_start(zr_r, zi_r);
    end
    if (state_r == B_PROD) begin
      rr_r <= fxm_finish(p_rr_r);
      ii_r <= fxm_finish(p_ii_r);
      ri_r <= fxm_finish(p_ri_r);
    end
    if (state_r == B_UPD && !finish) begin
      zr_r <= nr;
      zi_r <= ni;
      k_r  <= k_r + 1'b1;
    end
  end
endmodule

// ===== design/mbe_checker.sv =====
// Port-level checks of the escape-time block and their binding.
`include "mandelbrot_escape_iteration_defines.svh"

module mbe_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            push,
  input logic                            full,
  input logic                            empty,
  input logic [mbe_pkg::ITER_W-1:0]      out_iterations,
  input logic                            cfg_valid,
  input logic                            cfg_ready
);
  // A waiting count is never zero
  `MBE_ASSERT_NOW(a_count_nonzero, !empty, out_iterations != '0, "zero iteration count")
  // The front end goes busy once it takes a pixel
  `MBE_ASSERT_NEXT(a_busy_after_take, push && !full, full, "front took two pixels")
  // The result queue comes out of reset empty and the front end ready
  `MBE_ASSERT_NOW(a_empty_after_reset, $past(!rst_n), empty && !full, "queue not clear")
  // Configuration is always taken
  `MBE_ASSERT_NOW(a_cfg_ready, cfg_valid, cfg_ready, "configuration write refused")
endmodule

bind mandelbrot_escape_iteration mbe_checker u_mbe_checker (.*);

// ===== verif/mandelbrot_escape_iteration_tb.sv =====
// Self-checking testbench of the Mandelbrot escape-time block: directed and random pixels.
`timescale 1ns / 100ps

module mandelbrot_escape_iteration_tb;
  import mbe_pkg::*;

  localparam longint FX_HI      = 64'sh7FFF_FFFF_FFFF;
  localparam longint FX_LO      = -64'sh8000_0000_0000;
  localparam longint ESCAPE_NRM = 64'sd2 <<< 40;
  localparam int     CYCLE_CAP  = 3000000;
  localparam int     NUM_PHASES = 12;

  typedef struct {
    logic [ROW_W-1:0] row;
    logic [ROW_W-1:0] col;
    int               count;  // typed-in escape count, -1 to use the predictor
  } pixel_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 push;
  logic                 full;
  logic [ROW_W-1:0]     in_pixel_row;
  logic [ROW_W-1:0]     in_pixel_col;
  logic                 empty;
  logic                 pop;
  logic [ITER_W-1:0]    out_iterations;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;

  // Shadow copy of the view registers
  logic [SIZE_W-1:0]        view_size;
  logic signed [CTR_W-1:0]  view_cx;
  logic signed [CTR_W-1:0]  view_cy;
  logic [ZOOM_W-1:0]        view_zoom;
  logic [ITER_W-1:0]        view_limit;

  logic [ITER_W-1:0] pending_counts[$];
  int                errors;
  int                cycles;
  int                pop_pct;

  mandelbrot_escape_iteration DUT (
    .clk(clk), .rst_n(rst_n),
    .push(push), .full(full), .in_pixel_row(in_pixel_row), .in_pixel_col(in_pixel_col),
    .empty(empty), .pop(pop), .out_iterations(out_iterations),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic longint clamp48(input longint v);
    if (v > FX_HI) return FX_HI;
    if (v < FX_LO) return FX_LO;
    return v;
  endfunction

  function automatic longint signed_of(input bit neg, input longint unsigned mag);
    if (neg) begin
      if (mag >= 64'h8000_0000_0000) return FX_LO;
      return -longint'(mag);
    end
    if (mag > 64'h7FFF_FFFF_FFFF) return FX_HI;
    return longint'(mag);
  endfunction

  function automatic longint unsigned abs_of(input longint v);
    return (v < 0) ? longint'(-v) : v;
  endfunction

  // Q8.40 product, truncated toward zero, saturated
  function automatic longint q40_mul(input longint a, input longint b);
    bit neg;
    longint unsigned ma, mb, a1, a0, b1, b0, mid, lo, hi;
    neg = (a < 0) != (b < 0);
    ma = abs_of(a);
    mb = abs_of(b);
    a1 = ma >> 24;
    a0 = ma & 64'hFF_FFFF;
    b1 = mb >> 24;
    b0 = mb & 64'hFF_FFFF;
    mid = a1 * b0 + a0 * b1;
    lo = a0 * b0 + ((mid & 64'hFFFF) << 24);
    hi = a1 * b1;
    if (hi >= (64'd1 << 40)) return signed_of(neg, 64'd1 << 48);
    return signed_of(neg, (hi << 8) + (mid >> 16) + (lo >> 40));
  endfunction

  // Pixel offset (in half pixels) over size*zoom, as a Q8.40 coordinate
  function automatic longint plane_coord(input longint numh, input longint unsigned den);
    bit neg;
    longint unsigned a, q, r;
    neg = numh < 0;
    a = abs_of(numh);
    if (a == 0) return 0;
    if (den == 0) return signed_of(neg, 64'd1 << 48);
    q = a / den;
    r = a % den;
    for (int k = 0; k < MAP_SHIFT; k++) begin
      if (q >= (64'd1 << 47)) return signed_of(neg, 64'd1 << 48);
      r = r << 1;
      q = q << 1;
      if (r >= den) begin
        r = r - den;
        q = q | 64'd1;
      end
    end
    return signed_of(neg, q);
  endfunction

  // Escape count of one pixel under the current view
  function automatic logic [ITER_W-1:0] escape_count(input logic [ROW_W-1:0] row,
                                                     input logic [ROW_W-1:0] col);
    longint unsigned size, lim, den, k;
    longint cr, ci, zr, zi, rr, ii, ri, nrm;
    size = (view_size > MAX_SIZE) ? MAX_SIZE : view_size;
    lim = (view_limit > DEF_MAX_ITER) ? DEF_MAX_ITER : view_limit;
    den = size * view_zoom;
    cr = plane_coord(2 * longint'(col) - longint'(size) - 2 * longint'(view_cx), den);
    ci = plane_coord(2 * longint'(row) - longint'(size) - 2 * longint'(view_cy), den);
    zr = 0;
    zi = 0;
    k = 0;
    do begin
      rr = q40_mul(zr, zr);
      ii = q40_mul(zi, zi);
      ri = q40_mul(zr, zi);
      zr = clamp48(clamp48(rr - ii) + cr);
      zi = clamp48(clamp48(ri + ri) + ci);
      k++;
      nrm = clamp48(q40_mul(zr, zr) + q40_mul(zi, zi));
    end while (nrm < ESCAPE_NRM && k < lim);
    return k[ITER_W-1:0];
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Write one register word and update the shadow
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_IMAGE_SIZE: view_size  = val[SIZE_W-1:0];
      CFG_CENTER_X:   view_cx    = val[CTR_W-1:0];
      CFG_CENTER_Y:   view_cy    = val[CTR_W-1:0];
      CFG_ZOOM_SCALE: view_zoom  = val[ZOOM_W-1:0];
      CFG_MAX_ITER:   view_limit = val[ITER_W-1:0];
      default: ;
    endcase
  endtask

  // Send one pixel word; keep push high when no gap follows
  task automatic send_pixel(input logic [ROW_W-1:0] row, input logic [ROW_W-1:0] col,
                            input int count, input bit steady);
    int g;
    g = steady ? 0 : gap_len();
    if (g > 0) begin
      push <= 1'b0;
      repeat (g) @(posedge clk);
    end
    push         <= 1'b1;
    in_pixel_row <= row;
    in_pixel_col <= col;
    do @(posedge clk); while (full);
    pending_counts.push_back(count < 0 ? escape_count(row, col) : ITER_W'(count));
  endtask

  task automatic drain();
    push <= 1'b0;
    while (pending_counts.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Compare each popped word with the oldest expected count
  always @(posedge clk) begin
    if (rst_n && pop && !empty) begin
      if (pending_counts.size() == 0) begin
        $display("%0t: unexpected result, actual iterations=%0d", $time, out_iterations);
        errors++;
      end else begin
        if (out_iterations !== pending_counts[0]) begin
          $display("%0t: iterations expected %0d actual %0d", $time, pending_counts[0],
                   out_iterations);
          errors++;
        end
        void'(pending_counts.pop_front());
      end
    end
  end

  // Stall the receiver in changing patterns
  always @(posedge clk) begin
    if (cycles % 200 == 0) begin
      case ($urandom_range(0, 4))
        0, 1: pop_pct = 100;
        2:    pop_pct = 70;
        3:    pop_pct = 20;
        default: pop_pct = 3;
      endcase
    end
    pop <= ($urandom_range(0, 99) < pop_pct);
  end

  // Bound the run
  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_CAP) begin
      $display("mandelbrot_escape_iteration regression: fail");
      $finish;
    end
  end

  initial begin
    pixel_row_t directed[$];
    logic [SIZE_W-1:0] sz;
    logic [CTR_W-1:0] cx, cy;
    logic [ZOOM_W-1:0] zm;
    logic [ITER_W-1:0] lim;
    logic [ROW_W-1:0] r, c;
    int n_items;
    bit steady;

    clk = 1'b0;
    rst_n = 1'b0;
    push = 1'b0;
    pop = 1'b0;
    in_pixel_row = '0;
    in_pixel_col = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_IMAGE_SIZE;
    cfg_data = '0;
    errors = 0;
    cycles = 0;
    pop_pct = 100;
    view_size = RST_IMAGE_SIZE;
    view_cx = '0;
    view_cy = '0;
    view_zoom = RST_ZOOM_SCALE;
    view_limit = RST_MAX_ITER;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset view: center is c = 0, corners are far outside
    directed = '{
      '{11'd400,  11'd400,  100}, '{11'd0,    11'd0,    1},
      '{11'd2047, 11'd2047, 1},   '{11'd0,    11'd2047, 1},
      '{11'd2047, 11'd0,    1},   '{11'd400,  11'd300,  100},
      '{11'd400,  11'd500,  2},   '{11'd300,  11'd400,  2},
      '{11'd400,  11'd450,  -1},  '{11'd123,  11'd456,  -1},
      '{11'd799,  11'd799,  -1},  '{11'd800,  11'd800,  -1},
      '{11'd1024, 11'd1024, -1},  '{11'd1,    11'd2046, -1},
      '{11'd1365, 11'd682,  -1},  '{11'd410,  11'd330,  -1},
      '{11'd350,  11'd370,  -1},  '{11'd440,  11'd310,  -1}
    };
    foreach (directed[i])
      send_pixel(directed[i].row, directed[i].col, directed[i].count, i < 6);
    drain();

    // Random phases, each under a fresh view
    for (int p = 0; p < NUM_PHASES; p++) begin
      sz  = (p == 1) ? 12'd0 : (p == 2) ? 12'hFFF : (p == 3) ? 12'd100 :
            SIZE_W'($urandom_range(100, 2048));
      cx  = (p == 3) ? 15'h4000 : (p == 4) ? 15'h3FFF :
            ($urandom_range(0, 9) == 0) ? CTR_W'($urandom) : CTR_W'($urandom_range(0, 400) - 200);
      cy  = (p == 3) ? 15'h4000 : (p == 4) ? 15'h3FFF :
            ($urandom_range(0, 9) == 0) ? CTR_W'($urandom) : CTR_W'($urandom_range(0, 400) - 200);
      zm  = (p == 1) ? RST_ZOOM_SCALE : (p == 5) ? 32'd0 : (p == 6) ? 32'hFFFF_FFFF :
            (p == 7) ? 32'd1 : ($urandom_range(0, 9) == 0) ? $urandom :
            $urandom_range(32'h40_0000, 32'h400_0000);
      lim = (p == 8) ? 11'd0 : (p == 9) ? 11'h7FF : (p == 10) ? 11'd1024 :
            ITER_W'($urandom_range(1, 64));
      write_reg(CFG_IMAGE_SIZE, CFG_DAT_W'(sz));
      write_reg(CFG_CENTER_X, CFG_DAT_W'(cx));
      write_reg(CFG_CENTER_Y, CFG_DAT_W'(cy));
      write_reg(CFG_ZOOM_SCALE, zm);
      write_reg(CFG_MAX_ITER, CFG_DAT_W'(lim));
      cfg_valid <= 1'b0;
      @(posedge clk);

      n_items = (p == 9 || p == 10) ? 25 : 80;
      steady = (p % 3 == 0);
      for (int i = 0; i < n_items; i++) begin
        // Mostly pixels inside the image, a few anywhere
        if ($urandom_range(0, 9) == 0 || sz < 2) begin
          r = ROW_W'($urandom);
          c = ROW_W'($urandom);
        end else begin
          r = ROW_W'($urandom_range(0, (sz > MAX_SIZE ? MAX_SIZE : sz) - 1));
          c = ROW_W'($urandom_range(0, (sz > MAX_SIZE ? MAX_SIZE : sz) - 1));
        end
        send_pixel(r, c, -1, steady && i < n_items / 2);
      end
      drain();
    end

    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("mandelbrot_escape_iteration regression: pass");
    end else begin
      $display("mandelbrot_escape_iteration regression: fail");
    end
    $finish;
  end

endmodule
